[sv/lisr_pkg.sv]
// ----------------------------------------------------------------------------
// lisr_pkg
// shared types and constants of the linear interpolation stream resampler
// ----------------------------------------------------------------------------
package lisr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SAMPLE_W  = 16;
  localparam int STEP_W    = 23;
  // position stays below one sample plus one step
  localparam int POS_W     = STEP_W + 1;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int PROD_W    = DIFF_W + FRAC_BITS + 1;
  localparam int MAX_RUN   = 64;
  localparam int CNT_W     = $clog2(MAX_RUN);
  localparam int Q_DEPTH   = 2;
  localparam int QA_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W      = $clog2(Q_DEPTH + 1);

  localparam logic [POS_W-1:0]  ONE_POS    = POS_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(73881);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // one interpolation job: held sample and the sample that follows it
  typedef struct packed {
    sample_t held;
    sample_t fresh;
  } pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_EMIT
  } back_state_t;

endpackage

[sv/lisr_front.sv]
// ----------------------------------------------------------------------------
// lisr_front
// input side: primes the held sample and turns each later sample into a job
// ----------------------------------------------------------------------------
module lisr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  lisr_pkg::sample_t in_source_sample,
  input  lisr_pkg::q_stat_t q_stat,
  output logic              q_push,
  output lisr_pkg::pair_t   q_data
);

  logic              have_held_r;
  logic              have_held_nxt;
  lisr_pkg::sample_t held_r;
  lisr_pkg::sample_t held_nxt;
  logic              accept;

  assign full   = q_stat.full;
  assign accept = push & ~q_stat.full;

  // first sample only primes the store
  assign q_push = accept & have_held_r;
  assign q_data = '{held: held_r, fresh: in_source_sample};

  always_comb begin
    have_held_nxt = have_held_r | accept;
    held_nxt      = accept ? in_source_sample : held_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_held_r <= 1'b0;
    end else begin
      have_held_r <= have_held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

[sv/lisr_queue.sv]
// ----------------------------------------------------------------------------
// lisr_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module lisr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_push,
  input  lisr_pkg::pair_t   q_data,
  input  logic              q_pop,
  output lisr_pkg::pair_t   q_head,
  output lisr_pkg::q_stat_t q_stat
);

  lisr_pkg::pair_t                 mem_r [lisr_pkg::Q_DEPTH];
  logic [lisr_pkg::QA_W-1:0]       wr_ptr_r;
  logic [lisr_pkg::QA_W-1:0]       wr_ptr_nxt;
  logic [lisr_pkg::QA_W-1:0]       rd_ptr_r;
  logic [lisr_pkg::QA_W-1:0]       rd_ptr_nxt;
  logic [lisr_pkg::QC_W-1:0]       count_r;
  logic [lisr_pkg::QC_W-1:0]       count_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign q_stat  = '{full:  (count_r == lisr_pkg::QC_W'(lisr_pkg::Q_DEPTH)),
                     empty: (count_r == '0)};
  assign do_push = q_push & ~q_stat.full;
  assign do_pop  = q_pop & ~q_stat.empty;
  assign q_head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == lisr_pkg::QA_W'(lisr_pkg::Q_DEPTH - 1)) ?
                   '0 : wr_ptr_r + lisr_pkg::QA_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == lisr_pkg::QA_W'(lisr_pkg::Q_DEPTH - 1)) ?
                   '0 : rd_ptr_r + lisr_pkg::QA_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + lisr_pkg::QC_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - lisr_pkg::QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_data;
    end
  end

endmodule

[sv/lisr_back.sv]
// ----------------------------------------------------------------------------
// lisr_back
// back end: walks the output position across one job and emits samples
// ----------------------------------------------------------------------------
module lisr_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lisr_pkg::STEP_W-1:0]  step_ratio,
  input  lisr_pkg::pair_t              q_head,
  input  lisr_pkg::q_stat_t            q_stat,
  output logic                         q_pop,
  output logic                         empty,
  input  logic                         pop,
  output lisr_pkg::sample_t            out_sample,
  output logic                         out_last_of_run
);

  lisr_pkg::back_state_t                 state_r;
  lisr_pkg::back_state_t                 state_nxt;
  logic [lisr_pkg::POS_W-1:0]            pos_r;
  logic [lisr_pkg::POS_W-1:0]            pos_nxt;
  logic [lisr_pkg::CNT_W-1:0]            cnt_r;
  logic [lisr_pkg::CNT_W-1:0]            cnt_nxt;
  lisr_pkg::sample_t                     a_r;
  lisr_pkg::sample_t                     a_nxt;
  logic signed [lisr_pkg::DIFF_W-1:0]    diff_r;
  logic signed [lisr_pkg::DIFF_W-1:0]    diff_nxt;
  logic signed [lisr_pkg::PROD_W-1:0]    prod_r;
  logic signed [lisr_pkg::PROD_W-1:0]    prod_nxt;
  logic                                  last_r;
  logic                                  last_nxt;
  logic                                  out_valid_r;
  logic                                  out_valid_nxt;
  lisr_pkg::sample_t                     out_sample_r;
  lisr_pkg::sample_t                     out_sample_nxt;
  logic                                  out_last_r;
  logic                                  out_last_nxt;

  logic [lisr_pkg::FRAC_BITS-1:0]        frac;
  logic [lisr_pkg::POS_W-1:0]            pos_add;
  logic                                  pos_ge;
  logic                                  slot_free;
  logic signed [lisr_pkg::PROD_W-lisr_pkg::FRAC_BITS-1:0] interp;

  assign empty           = ~out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_last_of_run = out_last_r;

  assign frac      = pos_r[lisr_pkg::FRAC_BITS-1:0];
  assign pos_add   = pos_r + lisr_pkg::POS_W'(step_ratio);
  assign pos_ge    = (pos_add >= lisr_pkg::ONE_POS);
  assign slot_free = ~out_valid_r | pop;

  // a + floor((b - a) * frac / one)
  assign interp = prod_r[lisr_pkg::PROD_W-1:lisr_pkg::FRAC_BITS] +
                  (lisr_pkg::PROD_W - lisr_pkg::FRAC_BITS)'(a_r);

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    a_nxt          = a_r;
    diff_nxt       = diff_r;
    prod_nxt       = prod_r;
    last_nxt       = last_r;
    q_pop          = 1'b0;
    out_valid_nxt  = out_valid_r & ~pop;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      lisr_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (pos_r >= lisr_pkg::ONE_POS) begin
            // nothing due before the new sample
            pos_nxt = pos_r - lisr_pkg::ONE_POS;
          end else begin
            a_nxt     = q_head.held;
            diff_nxt  = lisr_pkg::DIFF_W'(q_head.fresh) - lisr_pkg::DIFF_W'(q_head.held);
            cnt_nxt   = '0;
            state_nxt = lisr_pkg::B_MUL;
          end
        end
      end
      lisr_pkg::B_MUL: begin
        prod_nxt = lisr_pkg::PROD_W'(diff_r * $signed({1'b0, frac}));
        last_nxt = pos_ge | (cnt_r == lisr_pkg::CNT_W'(lisr_pkg::MAX_RUN - 1));
        cnt_nxt  = cnt_r + lisr_pkg::CNT_W'(1);
        if (pos_ge) begin
          pos_nxt = last_nxt ? pos_add - lisr_pkg::ONE_POS : pos_add;
        end else begin
          // run cut short: position clamps to zero
          pos_nxt = last_nxt ? '0 : pos_add;
        end
        state_nxt = lisr_pkg::B_EMIT;
      end
      lisr_pkg::B_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = interp[lisr_pkg::SAMPLE_W-1:0];
          out_last_nxt   = last_r;
          state_nxt      = last_r ? lisr_pkg::B_IDLE : lisr_pkg::B_MUL;
        end
      end
      default: begin
        state_nxt = lisr_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lisr_pkg::B_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    diff_r       <= diff_nxt;
    prod_r       <= prod_nxt;
    last_r       <= last_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

[sv/linear_interp_stream_resampler.sv]
// ----------------------------------------------------------------------------
// linear_interp_stream_resampler
// linear interpolation resampler with a 7.16 source-per-output step
// ----------------------------------------------------------------------------
// Source samples go in through push/full and interpolated samples come out
// through empty/pop, oldest first. The first sample after reset only primes
// the held sample. Each later sample b, with held sample a, yields every output
// whose position lies before b, as a + floor((b - a) * frac / 65536), then the
// position drops by one sample; out_last_of_run marks the last output of a
// run, and a run stops after 64 outputs. Flow: a sample enters a two-entry
// job queue; the back end pops a job in its idle state, then for each output
// steps through a multiply state and a state that loads the output register,
// and takes no new job until the run ends. A sample giving no outputs is
// popped in the idle state while the position drops by one sample. A waiting
// result holds the back end only when the output register is still full.
// The user must see that cfg_step_ratio is written with cfg_we while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module linear_interp_stream_resampler (
  input  logic                         clk,
  input  logic                         rst_n,
  // input queue side
  input  logic                         push,
  output logic                         full,
  input  lisr_pkg::sample_t            in_source_sample,
  // result queue side
  output logic                         empty,
  input  logic                         pop,
  output lisr_pkg::sample_t            out_sample,
  output logic                         out_last_of_run,
  // step register
  input  logic                         cfg_we,
  input  logic [lisr_pkg::STEP_W-1:0]  cfg_step_ratio
);

  logic [lisr_pkg::STEP_W-1:0] step_r;
  logic [lisr_pkg::STEP_W-1:0] step_nxt;
  lisr_pkg::q_stat_t           q_stat;
  lisr_pkg::pair_t             q_data;
  lisr_pkg::pair_t             q_head;
  logic                        q_push;
  logic                        q_pop;

  // step register, reset to 49716 Hz into 44100 Hz
  assign step_nxt = cfg_we ? cfg_step_ratio : step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= lisr_pkg::STEP_RESET;
    end else begin
      step_r <= step_nxt;
    end
  end

  // front: priming and job build
  lisr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_source_sample (in_source_sample),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_data           (q_data)
  );

  // job queue decouples the input transfer from the output walk
  lisr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_data (q_data),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  // back: position walk, multiply and output register
  lisr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_ratio      (step_r),
    .q_head          (q_head),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_sample      (out_sample),
    .out_last_of_run (out_last_of_run)
  );

endmodule
